[rtl/mrc_pkg.sv]
`timescale 1ns / 1ps
package mrc_pkg;

  localparam int COIL_COUNT_DEF      = 16;
  localparam int DISCRETE_COUNT_DEF  = 16;
  localparam int HOLDING_COUNT_DEF   = 16;
  localparam int INPUT_COUNT_DEF     = 16;
  localparam int MAX_READ_COUNT_DEF  = 125;
  localparam int MIN_FRAME_BYTES_DEF = 4;

  localparam int QUEUE_DEPTH = 2;
  localparam int HDR_BYTES   = 6;
  localparam int REQ_LEN     = 8;
  localparam int CNT_W       = 9;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [7:0]  FC_EXC_FLAG = 8'h80;
  localparam logic [7:0]  COIL_ON_BYTE = 8'hFF;

  localparam logic [7:0] FC_READ_COILS    = 8'd1;
  localparam logic [7:0] FC_READ_DISCRETE = 8'd2;
  localparam logic [7:0] FC_READ_HOLDING  = 8'd3;
  localparam logic [7:0] FC_READ_INPUT    = 8'd4;
  localparam logic [7:0] FC_WRITE_COIL    = 8'd5;
  localparam logic [7:0] FC_WRITE_REG     = 8'd6;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STATION_ADDRESS = 3'd0,
    REG_FUNCTION_ENABLE = 3'd1,
    REG_COIL_START      = 3'd2,
    REG_DISCRETE_START  = 3'd3,
    REG_HOLDING_START   = 3'd4,
    REG_INPUT_REG_START = 3'd5
  } reg_index_t;

  typedef enum logic [1:0] {
    VERDICT_BAD    = 2'd0,
    VERDICT_OTHER  = 2'd1,
    VERDICT_ACCEPT = 2'd2,
    VERDICT_EXCEPT = 2'd3
  } verdict_t;

  typedef enum logic [1:0] {
    EXC_NONE      = 2'd0,
    EXC_ILL_FUNC  = 2'd1,
    EXC_ILL_ADDR  = 2'd2,
    EXC_ILL_VALUE = 2'd3
  } exc_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_end;
  } in_t;

  typedef struct packed {
    verdict_t    verdict;
    logic [7:0]  function_code;
    logic [15:0] start_address;
    logic [15:0] count_or_value;
    logic [7:0]  reply_byte_count;
    logic        coil_on;
    exc_t        exception_code;
    logic [15:0] exception_reply_crc;
  } out_t;

  typedef struct packed {
    logic [7:0]  station_address;
    logic [5:0]  function_enable;
    logic [15:0] coil_start;
    logic [15:0] discrete_start;
    logic [15:0] holding_start;
    logic [15:0] input_reg_start;
  } cfg_t;

  // summary of one received frame, handed from front to back
  typedef struct packed {
    logic                      bad;
    logic                      len8;
    logic [HDR_BYTES-1:0][7:0] hdr;
  } frame_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

[rtl/mrc_front.sv]
`timescale 1ns / 1ps
module mrc_front #(
  parameter int MIN_FRAME_BYTES = mrc_pkg::MIN_FRAME_BYTES_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            accept,
  input  mrc_pkg::in_t    rx,
  output logic            push,
  output mrc_pkg::frame_t push_data
);

  localparam logic [mrc_pkg::CNT_W-1:0] CNT_MAX = {mrc_pkg::CNT_W{1'b1}};

  logic [15:0]               crc;
  logic [15:0]               crc_next;
  logic [mrc_pkg::CNT_W-1:0] count;
  logic [mrc_pkg::CNT_W-1:0] count_next;
  logic [mrc_pkg::HDR_BYTES-1:0][7:0] hdr;
  logic [mrc_pkg::HDR_BYTES-1:0][7:0] hdr_next;
  logic                      hdr_wr;

  assign crc_next   = mrc_pkg::crc16_byte(crc, rx.data_byte);
  assign count_next = (count == CNT_MAX) ? count : count + 1'b1;
  assign hdr_wr     = count < mrc_pkg::CNT_W'(mrc_pkg::HDR_BYTES);

  always_comb begin
    hdr_next = hdr;
    if (hdr_wr) begin
      hdr_next[count[2:0]] = rx.data_byte;
    end
  end

  assign push = accept && rx.frame_end;

  always_comb begin
    push_data.bad  = (count_next < mrc_pkg::CNT_W'(MIN_FRAME_BYTES)) || (crc_next != 16'h0000);
    push_data.len8 = count_next == mrc_pkg::CNT_W'(mrc_pkg::REQ_LEN);
    push_data.hdr  = hdr_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc   <= mrc_pkg::CRC_INIT;
      count <= '0;
    end else if (accept) begin
      crc   <= rx.frame_end ? mrc_pkg::CRC_INIT : crc_next;
      count <= rx.frame_end ? '0 : count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hdr <= hdr_next;
    end
  end

endmodule

[rtl/mrc_queue.sv]
`timescale 1ns / 1ps
module mrc_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  mrc_pkg::frame_t push_data,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output mrc_pkg::frame_t head
);

  localparam int DEPTH = mrc_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  mrc_pkg::frame_t  entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;
  logic             do_push;
  logic             do_pop;

  assign full       = fill == CNT_W'(DEPTH);
  assign head_valid = fill != '0;
  assign head       = entries[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

[rtl/mrc_back.sv]
`timescale 1ns / 1ps
module mrc_back #(
  parameter int COIL_COUNT     = mrc_pkg::COIL_COUNT_DEF,
  parameter int DISCRETE_COUNT = mrc_pkg::DISCRETE_COUNT_DEF,
  parameter int HOLDING_COUNT  = mrc_pkg::HOLDING_COUNT_DEF,
  parameter int INPUT_COUNT    = mrc_pkg::INPUT_COUNT_DEF,
  parameter int MAX_READ_COUNT = mrc_pkg::MAX_READ_COUNT_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  mrc_pkg::cfg_t   cfg,
  input  logic            head_valid,
  input  mrc_pkg::frame_t head,
  output logic            pop,
  output logic            res_valid,
  input  logic            res_stall,
  output mrc_pkg::out_t   res_data
);

  localparam logic [7:0] COIL_RBC     = 8'((COIL_COUNT + 7) / 8);
  localparam logic [7:0] DISCRETE_RBC = 8'((DISCRETE_COUNT + 7) / 8);

  logic          advance;
  logic [7:0]    fc;
  logic [15:0]   addr;
  logic [15:0]   cnt;
  logic          fc_ok;
  logic [2:0]    fc_idx;
  mrc_pkg::exc_t exc;
  logic [7:0]    rbc;
  logic          coil;
  logic [15:0]   reg_start;
  logic [16:0]   reg_block;
  logic [16:0]   coil_end;
  logic [16:0]   holding_end;
  logic [15:0]   crc_pre;
  mrc_pkg::out_t a_next;
  logic [15:0]   exc_crc;
  mrc_pkg::out_t b_next;

  // stage a: classified request, exception crc over address and function
  logic          a_valid;
  mrc_pkg::out_t a_data;

  assign advance = !res_valid || !res_stall;
  assign pop     = advance && head_valid;

  assign fc     = head.hdr[1];
  assign addr   = head.len8 ? {head.hdr[2], head.hdr[3]} : 16'h0000;
  assign cnt    = head.len8 ? {head.hdr[4], head.hdr[5]} : 16'h0000;
  assign fc_idx = fc[2:0] - 3'd1;
  assign fc_ok  = (fc >= mrc_pkg::FC_READ_COILS) && (fc <= mrc_pkg::FC_WRITE_REG)
                  && cfg.function_enable[fc_idx];

  assign reg_start   = (fc == mrc_pkg::FC_READ_HOLDING) ? cfg.holding_start
                                                        : cfg.input_reg_start;
  assign reg_block   = (fc == mrc_pkg::FC_READ_HOLDING) ? 17'(HOLDING_COUNT)
                                                        : 17'(INPUT_COUNT);
  assign coil_end    = {1'b0, cfg.coil_start} + 17'(COIL_COUNT);
  assign holding_end = {1'b0, cfg.holding_start} + 17'(HOLDING_COUNT);

  always_comb begin
    exc  = mrc_pkg::EXC_NONE;
    rbc  = 8'h00;
    coil = 1'b0;
    if (!fc_ok) begin
      exc = mrc_pkg::EXC_ILL_FUNC;
    end else if (!head.len8) begin
      exc = mrc_pkg::EXC_ILL_VALUE;
    end else begin
      unique case (fc) inside
        mrc_pkg::FC_READ_COILS: begin
          if (addr != cfg.coil_start || cnt != 16'(COIL_COUNT)) begin
            exc = mrc_pkg::EXC_ILL_ADDR;
          end
          rbc = COIL_RBC;
        end
        mrc_pkg::FC_READ_DISCRETE: begin
          if (addr != cfg.discrete_start || cnt != 16'(DISCRETE_COUNT)) begin
            exc = mrc_pkg::EXC_ILL_ADDR;
          end
          rbc = DISCRETE_RBC;
        end
        mrc_pkg::FC_READ_HOLDING, mrc_pkg::FC_READ_INPUT: begin
          if (cnt == 16'h0000 || cnt > 16'(MAX_READ_COUNT)) begin
            exc = mrc_pkg::EXC_ILL_VALUE;
          end else if (addr < reg_start ||
                       ({1'b0, addr} + {1'b0, cnt}) > ({1'b0, reg_start} + reg_block)) begin
            exc = mrc_pkg::EXC_ILL_ADDR;
          end
          rbc = {cnt[6:0], 1'b0};
        end
        mrc_pkg::FC_WRITE_COIL: begin
          if (cnt[7:0] != 8'h00 ||
              (cnt[15:8] != 8'h00 && cnt[15:8] != mrc_pkg::COIL_ON_BYTE)) begin
            exc = mrc_pkg::EXC_ILL_VALUE;
          end else if (addr < cfg.coil_start || {1'b0, addr} >= coil_end) begin
            exc = mrc_pkg::EXC_ILL_ADDR;
          end
          coil = cnt[15:8] == mrc_pkg::COIL_ON_BYTE;
        end
        default: begin
          if (addr < cfg.holding_start || {1'b0, addr} >= holding_end) begin
            exc = mrc_pkg::EXC_ILL_ADDR;
          end
        end
      endcase
    end
  end

  assign crc_pre = mrc_pkg::crc16_byte(mrc_pkg::crc16_byte(mrc_pkg::CRC_INIT,
                                       cfg.station_address), fc | mrc_pkg::FC_EXC_FLAG);

  always_comb begin
    a_next = '0;
    if (!head.bad) begin
      a_next.function_code = fc;
      if (head.hdr[0] != cfg.station_address) begin
        a_next.verdict = mrc_pkg::VERDICT_OTHER;
      end else if (exc == mrc_pkg::EXC_NONE) begin
        a_next.verdict          = mrc_pkg::VERDICT_ACCEPT;
        a_next.start_address    = addr;
        a_next.count_or_value   = cnt;
        a_next.reply_byte_count = rbc;
        a_next.coil_on          = coil;
      end else begin
        a_next.verdict             = mrc_pkg::VERDICT_EXCEPT;
        a_next.start_address       = addr;
        a_next.count_or_value      = cnt;
        a_next.exception_code      = exc;
        // finished with the exception code byte in the next stage
        a_next.exception_reply_crc = crc_pre;
      end
    end
  end

  assign exc_crc = mrc_pkg::crc16_byte(a_data.exception_reply_crc,
                                       {6'b0, a_data.exception_code});

  always_comb begin
    b_next = a_data;
    if (a_data.verdict == mrc_pkg::VERDICT_EXCEPT) begin
      b_next.exception_reply_crc = exc_crc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      res_valid <= 1'b0;
    end else if (advance) begin
      a_valid   <= head_valid;
      res_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      a_data   <= a_next;
      res_data <= b_next;
    end
  end

endmodule

[rtl/modbus_rtu_request_checker.sv]
`timescale 1ns / 1ps
// Checks received Modbus RTU request frames. One byte is taken per clock while rx_stall is low; rx_stall
// rises only while both slots of the two-frame queue between the byte front end
// and the checking back end are full, which happens only when results are held
// off on res_stall. The verdict of a frame reaches res through the queue write,
// the classify stage and the output register, one result per frame. Configuration
// writes take effect on the next clock and are meant to be made while no frame is
// in flight.
module modbus_rtu_request_checker #(
  parameter int COIL_COUNT      = mrc_pkg::COIL_COUNT_DEF,
  parameter int DISCRETE_COUNT  = mrc_pkg::DISCRETE_COUNT_DEF,
  parameter int HOLDING_COUNT   = mrc_pkg::HOLDING_COUNT_DEF,
  parameter int INPUT_COUNT     = mrc_pkg::INPUT_COUNT_DEF,
  parameter int MAX_READ_COUNT  = mrc_pkg::MAX_READ_COUNT_DEF,
  parameter int MIN_FRAME_BYTES = mrc_pkg::MIN_FRAME_BYTES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           rx_valid,
  output logic                           rx_stall,
  input  mrc_pkg::in_t                   rx_data,
  output logic                           res_valid,
  input  logic                           res_stall,
  output mrc_pkg::out_t                  res_data,
  input  logic                           cfg_we,
  input  logic [mrc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mrc_pkg::CFG_DATA_W-1:0] cfg_data
);

  mrc_pkg::cfg_t   cfg;
  logic            accept;
  logic            push;
  mrc_pkg::frame_t push_data;
  logic            full;
  logic            pop;
  logic            head_valid;
  mrc_pkg::frame_t head;

  assign rx_stall = full;
  assign accept   = rx_valid && !rx_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.station_address <= 8'd1;
      cfg.function_enable <= 6'h3F;
      cfg.coil_start      <= 16'h0000;
      cfg.discrete_start  <= 16'h0000;
      cfg.holding_start   <= 16'h0000;
      cfg.input_reg_start <= 16'h0000;
    end else if (cfg_we) begin
      unique case (mrc_pkg::reg_index_t'(cfg_index))
        mrc_pkg::REG_STATION_ADDRESS: cfg.station_address <= cfg_data[7:0];
        mrc_pkg::REG_FUNCTION_ENABLE: cfg.function_enable <= cfg_data[5:0];
        mrc_pkg::REG_COIL_START:      cfg.coil_start      <= cfg_data;
        mrc_pkg::REG_DISCRETE_START:  cfg.discrete_start  <= cfg_data;
        mrc_pkg::REG_HOLDING_START:   cfg.holding_start   <= cfg_data;
        mrc_pkg::REG_INPUT_REG_START: cfg.input_reg_start <= cfg_data;
        default: ;
      endcase
    end
  end

  mrc_front #(
    .MIN_FRAME_BYTES(MIN_FRAME_BYTES)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .rx       (rx_data),
    .push     (push),
    .push_data(push_data)
  );

  mrc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .head_valid(head_valid),
    .head      (head)
  );

  mrc_back #(
    .COIL_COUNT    (COIL_COUNT),
    .DISCRETE_COUNT(DISCRETE_COUNT),
    .HOLDING_COUNT (HOLDING_COUNT),
    .INPUT_COUNT   (INPUT_COUNT),
    .MAX_READ_COUNT(MAX_READ_COUNT)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .head_valid(head_valid),
    .head      (head),
    .pop       (pop),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data)
  );

endmodule

[rtl/mrc_checker.sv]
`timescale 1ns / 1ps
module mrc_checker (
  input logic          clk,
  input logic          rst,
  input logic          res_valid,
  input logic          res_stall,
  input mrc_pkg::out_t res_data
);

  // a held result keeps its value
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res_data))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result present right after reset");

  // a bad frame verdict has clear function code, address, count/value, exception code and crc fields
  a_bad_clean: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_data.verdict == mrc_pkg::VERDICT_BAD |->
      res_data.function_code == 8'h00 && res_data.start_address == 16'h0000 &&
      res_data.count_or_value == 16'h0000 && res_data.exception_code == mrc_pkg::EXC_NONE &&
      res_data.exception_reply_crc == 16'h0000)
    else $error("bad frame verdict with payload");

  a_exc_code: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_data.verdict == mrc_pkg::VERDICT_EXCEPT |->
      res_data.exception_code != mrc_pkg::EXC_NONE && res_data.reply_byte_count == 8'h00 &&
      !res_data.coil_on)
    else $error("exception verdict inconsistent");

endmodule

bind modbus_rtu_request_checker mrc_checker u_mrc_checker (
  .clk      (clk),
  .rst      (rst),
  .res_valid(res_valid),
  .res_stall(res_stall),
  .res_data (res_data)
);

[verif/tb_top.sv]
`timescale 1ns / 1ps
module tb_top;
  import mrc_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        rx_valid = 1'b0;
  logic        rx_stall;
  in_t         rx_data = '0;
  logic        res_valid;
  logic        res_stall = 1'b0;
  out_t        res_data;
  logic        cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // shadow of the checker: configuration, running crc, length and header bytes
  cfg_t          m_cfg;
  logic [15:0]   m_crc;
  int unsigned   m_count;
  logic [7:0]    m_hdr [HDR_BYTES];
  out_t          pending_verdicts [$];

  logic [7:0]    frame_buf [$];
  int            error_count = 0;
  int            bytes_sent = 0;
  bit            steady = 1'b0;

  modbus_rtu_request_checker dut (
    .clk       (clk),
    .rst       (rst),
    .rx_valid  (rx_valid),
    .rx_stall  (rx_stall),
    .rx_data   (rx_data),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] r;
    r = crc ^ {8'h00, b};
    repeat (8) begin
      if (r[0]) r = (r >> 1) ^ CRC_POLY;
      else r = r >> 1;
    end
    return r;
  endfunction

  // exception code of a request from our own station; also reply byte count and coil state
  function automatic exc_t judge_request(input logic [7:0] fc, input int unsigned len,
                                         input int unsigned addr, input int unsigned cnt,
                                         output logic [7:0] rbc, output logic coil);
    int unsigned base;
    int unsigned span;
    rbc = '0;
    coil = 1'b0;
    if (fc < FC_READ_COILS || fc > FC_WRITE_REG || !m_cfg.function_enable[fc - 8'd1])
      return EXC_ILL_FUNC;
    if (len != REQ_LEN) return EXC_ILL_VALUE;
    case (fc) inside
      FC_READ_COILS, FC_READ_DISCRETE: begin
        base = (fc == FC_READ_COILS) ? 32'(m_cfg.coil_start) : 32'(m_cfg.discrete_start);
        span = (fc == FC_READ_COILS) ? COIL_COUNT_DEF : DISCRETE_COUNT_DEF;
        if (addr != base || cnt != span) return EXC_ILL_ADDR;
        rbc = 8'((span + 7) >> 3);
      end
      FC_READ_HOLDING, FC_READ_INPUT: begin
        base = (fc == FC_READ_HOLDING) ? 32'(m_cfg.holding_start)
                                       : 32'(m_cfg.input_reg_start);
        span = (fc == FC_READ_HOLDING) ? HOLDING_COUNT_DEF : INPUT_COUNT_DEF;
        if (cnt == 0 || cnt > MAX_READ_COUNT_DEF) return EXC_ILL_VALUE;
        // no 16-bit wrap on the range end
        if (addr < base || addr + cnt > base + span) return EXC_ILL_ADDR;
        rbc = 8'(cnt << 1);
      end
      FC_WRITE_COIL: begin
        if ((cnt & 32'hFF) != 0) return EXC_ILL_VALUE;
        if ((cnt >> 8) != 0 && (cnt >> 8) != COIL_ON_BYTE) return EXC_ILL_VALUE;
        if (addr < m_cfg.coil_start || addr >= m_cfg.coil_start + COIL_COUNT_DEF)
          return EXC_ILL_ADDR;
        coil = ((cnt >> 8) == COIL_ON_BYTE);
      end
      default: begin
        if (addr < m_cfg.holding_start || addr >= m_cfg.holding_start + HOLDING_COUNT_DEF)
          return EXC_ILL_ADDR;
      end
    endcase
    return EXC_NONE;
  endfunction

  function automatic void judge_byte(input in_t it);
    out_t        r;
    int unsigned len;
    int unsigned a;
    int unsigned v;
    logic [15:0] c;
    logic [7:0]  fc;
    logic [7:0]  rbc;
    logic        coil;
    exc_t        e;
    if (m_count < HDR_BYTES) m_hdr[m_count] = it.data_byte;
    m_crc = crc_update(m_crc, it.data_byte);
    if (m_count < (1 << CNT_W) - 1) m_count++;
    if (!it.frame_end) return;
    len = m_count;
    c = m_crc;
    m_crc = CRC_INIT;
    m_count = 0;
    r = '0;
    if (len < MIN_FRAME_BYTES_DEF || c != 16'h0000) begin
      pending_verdicts.push_back(r);
      return;
    end
    fc = m_hdr[1];
    r.function_code = fc;
    if (m_hdr[0] != m_cfg.station_address) begin
      r.verdict = VERDICT_OTHER;
      pending_verdicts.push_back(r);
      return;
    end
    a = 0;
    v = 0;
    if (len == REQ_LEN) begin
      a = 32'({m_hdr[2], m_hdr[3]});
      v = 32'({m_hdr[4], m_hdr[5]});
      r.start_address = 16'(a);
      r.count_or_value = 16'(v);
    end
    e = judge_request(fc, len, a, v, rbc, coil);
    if (e == EXC_NONE) begin
      r.verdict = VERDICT_ACCEPT;
      r.reply_byte_count = rbc;
      r.coil_on = coil;
    end else begin
      r.verdict = VERDICT_EXCEPT;
      r.exception_code = e;
      c = crc_update(CRC_INIT, m_cfg.station_address);
      c = crc_update(c, fc | FC_EXC_FLAG);
      r.exception_reply_crc = crc_update(c, {6'b0, e});
    end
    pending_verdicts.push_back(r);
  endfunction

  task automatic flag_error(input string what);
    if (error_count < 40) $display("[%0t] error: %s", $time, what);
    error_count++;
  endtask

  task automatic check_verdict(input out_t got);
    out_t want;
    if (pending_verdicts.size() == 0) begin
      flag_error("result with no request pending");
      return;
    end
    want = pending_verdicts.pop_front();
    if (got.verdict !== want.verdict)
      flag_error($sformatf("verdict %0d, want %0d", got.verdict, want.verdict));
    if (got.function_code !== want.function_code)
      flag_error($sformatf("function_code %h, want %h", got.function_code,
                           want.function_code));
    if (got.start_address !== want.start_address)
      flag_error($sformatf("start_address %h, want %h", got.start_address,
                           want.start_address));
    if (got.count_or_value !== want.count_or_value)
      flag_error($sformatf("count_or_value %h, want %h", got.count_or_value,
                           want.count_or_value));
    if (got.reply_byte_count !== want.reply_byte_count)
      flag_error($sformatf("reply_byte_count %0d, want %0d", got.reply_byte_count,
                           want.reply_byte_count));
    if (got.coil_on !== want.coil_on)
      flag_error($sformatf("coil_on %b, want %b", got.coil_on, want.coil_on));
    if (got.exception_code !== want.exception_code)
      flag_error($sformatf("exception_code %0d, want %0d", got.exception_code,
                           want.exception_code));
    if (got.exception_reply_crc !== want.exception_reply_crc)
      flag_error($sformatf("exception_reply_crc %h, want %h", got.exception_reply_crc,
                           want.exception_reply_crc));
  endtask

  // called right after a rising edge; returns right after the edge that takes the byte
  task automatic send_byte(input logic [7:0] b, input logic last);
    int   gap;
    in_t  it;
    gap = steady ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      rx_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    it.data_byte = b;
    it.frame_end = last;
    rx_valid <= 1'b1;
    rx_data <= it;
    do @(negedge clk); while (rx_stall !== 1'b0);
    @(posedge clk);
    judge_byte(it);
    bytes_sent++;
  endtask

  task automatic send_raw();
    for (int i = 0; i < frame_buf.size(); i++)
      send_byte(frame_buf[i], i == frame_buf.size() - 1);
  endtask

  // appends the crc low byte first; a bad frame gets one flipped bit anywhere
  task automatic send_frame(input bit good);
    logic [15:0] c;
    int          pos;
    c = CRC_INIT;
    for (int i = 0; i < frame_buf.size(); i++) c = crc_update(c, frame_buf[i]);
    frame_buf.push_back(c[7:0]);
    frame_buf.push_back(c[15:8]);
    if (!good) begin
      pos = $urandom_range(0, frame_buf.size() - 1);
      frame_buf[pos] = frame_buf[pos] ^ (8'h01 << $urandom_range(0, 7));
    end
    send_raw();
  endtask

  task automatic put_request(input logic [7:0] st, input logic [7:0] fc,
                             input logic [15:0] a, input logic [15:0] v);
    frame_buf.delete();
    frame_buf.push_back(st);
    frame_buf.push_back(fc);
    frame_buf.push_back(a[15:8]);
    frame_buf.push_back(a[7:0]);
    frame_buf.push_back(v[15:8]);
    frame_buf.push_back(v[7:0]);
  endtask

  task automatic request(input logic [7:0] fc, input logic [15:0] a, input logic [15:0] v);
    put_request(m_cfg.station_address, fc, a, v);
    send_frame(1'b1);
  endtask

  // writes only once every verdict is in and the pipeline has emptied
  task automatic write_reg(input reg_index_t idx, input logic [15:0] val);
    rx_valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_STATION_ADDRESS: m_cfg.station_address = val[7:0];
      REG_FUNCTION_ENABLE: m_cfg.function_enable = val[5:0];
      REG_COIL_START:      m_cfg.coil_start = val;
      REG_DISCRETE_START:  m_cfg.discrete_start = val;
      REG_HOLDING_START:   m_cfg.holding_start = val;
      REG_INPUT_REG_START: m_cfg.input_reg_start = val;
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [7:0] st, input logic [5:0] en,
                            input logic [15:0] cs, input logic [15:0] ds,
                            input logic [15:0] hs, input logic [15:0] is);
    write_reg(REG_STATION_ADDRESS, {8'h00, st});
    write_reg(REG_FUNCTION_ENABLE, {10'b0, en});
    write_reg(REG_COIL_START, cs);
    write_reg(REG_DISCRETE_START, ds);
    write_reg(REG_HOLDING_START, hs);
    write_reg(REG_INPUT_REG_START, is);
  endtask

  task automatic test_bad_frames();
    frame_buf.delete();
    send_frame(1'b1);                       // crc only, two bytes
    frame_buf.delete();
    frame_buf.push_back(m_cfg.station_address);
    send_frame(1'b1);                       // three bytes with good crc, still short
    frame_buf.delete();
    frame_buf.push_back(8'h00);
    send_raw();
    put_request(m_cfg.station_address, FC_READ_HOLDING, 16'h0000, 16'h0001);
    send_frame(1'b0);
  endtask

  task automatic test_other_station();
    put_request(m_cfg.station_address ^ 8'h01, FC_READ_COILS, 16'h0000, 16'd16);
    send_frame(1'b1);
    put_request(8'h00, FC_WRITE_REG, 16'h0001, 16'h1234);
    send_frame(1'b1);
  endtask

  task automatic test_accepted();
    request(FC_READ_COILS, 16'h0000, 16'd16);
    request(FC_READ_DISCRETE, 16'h0000, 16'd16);
    request(FC_READ_HOLDING, 16'h0000, 16'd16);
    request(FC_READ_INPUT, 16'd15, 16'd1);
    request(FC_WRITE_COIL, 16'd3, {COIL_ON_BYTE, 8'h00});
    request(FC_WRITE_COIL, 16'd15, 16'h0000);
    request(FC_WRITE_REG, 16'h0000, 16'hFFFF);
  endtask

  task automatic test_exceptions();
    request(8'h00, 16'h0000, 16'h0001);
    request(8'h07, 16'h0000, 16'h0001);
    request(8'hFF, 16'hFFFF, 16'hFFFF);
    request(FC_READ_COILS, 16'h0000, 16'd15);
    request(FC_READ_HOLDING, 16'h0000, 16'd0);
    request(FC_READ_INPUT, 16'h0000, 16'(MAX_READ_COUNT_DEF + 1));
    request(FC_READ_HOLDING, 16'd10, 16'd7);
    request(FC_WRITE_COIL, 16'd0, 16'h00FF);
    request(FC_WRITE_COIL, 16'd0, 16'h1200);
    request(FC_WRITE_COIL, 16'd16, {COIL_ON_BYTE, 8'h00});
    request(FC_WRITE_REG, 16'd16, 16'h0000);
    // supported function with a short body fails on length first
    put_request(m_cfg.station_address, FC_READ_HOLDING, 16'h0000, 16'h0001);
    void'(frame_buf.pop_back());
    send_frame(1'b1);
    write_reg(REG_FUNCTION_ENABLE, 16'h003E);
    request(FC_READ_COILS, 16'h0000, 16'd16);
    write_reg(REG_FUNCTION_ENABLE, 16'h003F);
  endtask

  task automatic test_long_frame();
    frame_buf.delete();
    frame_buf.push_back(m_cfg.station_address);
    frame_buf.push_back(FC_READ_HOLDING);
    repeat (511) frame_buf.push_back(8'($urandom));
    send_frame(1'b1);
  endtask

  task automatic random_frame();
    int          kind;
    int          n;
    logic [7:0]  st;
    logic [7:0]  fc;
    logic [15:0] base;
    logic [15:0] a;
    logic [15:0] v;
    steady = ($urandom_range(0, 7) == 0);
    kind = $urandom_range(0, 99);
    case ($urandom_range(0, 9))
      8: st = 8'h00;
      9: st = 8'($urandom);
      default: st = m_cfg.station_address;
    endcase
    fc = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(1, 6)) : 8'($urandom);
    case (fc) inside
      FC_READ_COILS, FC_WRITE_COIL: base = m_cfg.coil_start;
      FC_READ_DISCRETE:             base = m_cfg.discrete_start;
      FC_READ_HOLDING, FC_WRITE_REG: base = m_cfg.holding_start;
      FC_READ_INPUT:                base = m_cfg.input_reg_start;
      default:                      base = 16'($urandom);
    endcase
    frame_buf.delete();
    if (kind < 70) begin
      if ($urandom_range(0, 3) == 0) a = 16'($urandom);
      else a = base + 16'($urandom_range(0, 20)) - 16'd2;
      case (fc) inside
        FC_READ_COILS, FC_READ_DISCRETE:
          v = ($urandom_range(0, 3) != 0) ? 16'd16 : 16'($urandom_range(0, 20));
        FC_READ_HOLDING, FC_READ_INPUT: begin
          case ($urandom_range(0, 5))
            0: v = 16'd0;
            1: v = 16'(MAX_READ_COUNT_DEF);
            2: v = 16'(MAX_READ_COUNT_DEF + 1);
            3: v = 16'($urandom);
            default: v = 16'($urandom_range(1, 8));
          endcase
        end
        FC_WRITE_COIL: begin
          case ($urandom_range(0, 3))
            0: v = 16'h0000;
            3: v = 16'($urandom);
            default: v = {COIL_ON_BYTE, 8'h00};
          endcase
        end
        default: v = 16'($urandom);
      endcase
      put_request(st, fc, a, v);
      send_frame($urandom_range(0, 9) != 0);
    end else if (kind < 82) begin
      frame_buf.push_back(st);
      frame_buf.push_back(fc);
      n = $urandom_range(0, 8);
      repeat (n) frame_buf.push_back(8'($urandom));
      send_frame($urandom_range(0, 9) != 0);
    end else if (kind < 92) begin
      // line noise, crc almost never right
      n = $urandom_range(1, 10);
      repeat (n) frame_buf.push_back(8'($urandom));
      send_raw();
    end else begin
      if ($urandom_range(0, 1) == 1) frame_buf.push_back(st);
      send_frame(1'b1);
    end
  endtask

  task automatic test_random();
    int stop_at;
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: set_config(8'd1, 6'h3F, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        1: set_config(8'hFF, 6'h3F, 16'hFFFF, 16'hFFF0, 16'hFFF8, 16'hFFFF);
        2: set_config(8'h00, 6'($urandom), 16'($urandom), 16'($urandom),
                      16'($urandom), 16'($urandom));
        3: set_config(8'($urandom), 6'h00, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF);
        default: set_config(8'($urandom), 6'($urandom), 16'($urandom_range(0, 40)),
                            16'($urandom), 16'($urandom_range(0, 40)), 16'($urandom));
      endcase
      stop_at = bytes_sent + 50;
      while (bytes_sent < stop_at) random_frame();
    end
    steady = 1'b0;
  endtask

  initial begin : verdict_monitor
    out_t got;
    int   hold;
    @(negedge rst);
    forever begin
      hold = steady ? 0 : $urandom_range(0, 3);
      if (hold != 0) begin
        res_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      res_stall <= 1'b0;
      do @(negedge clk); while (res_valid !== 1'b1);
      got = res_data;
      @(posedge clk);
      check_verdict(got);
    end
  end

  initial begin
    m_cfg.station_address = 8'd1;
    m_cfg.function_enable = 6'h3F;
    m_cfg.coil_start = '0;
    m_cfg.discrete_start = '0;
    m_cfg.holding_start = '0;
    m_cfg.input_reg_start = '0;
    m_crc = CRC_INIT;
    m_count = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_bad_frames();
    test_other_station();
    test_accepted();
    test_exceptions();
    test_long_frame();
    test_random();
    rx_valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end

endmodule

[filelist.f]
rtl/mrc_pkg.sv
rtl/mrc_front.sv
rtl/mrc_queue.sv
rtl/mrc_back.sv
rtl/modbus_rtu_request_checker.sv
rtl/mrc_checker.sv
verif/tb_top.sv
